@@ hw/rtl/jse_pkg.sv @@
// jse_pkg: shared types, character codes and helpers for the JSON string escaper.
// No dependencies; imported by json_string_escaper_core and tb_top.
package jse_pkg;

  localparam int MaxRes = 12;
  localparam int CntW   = $clog2(MaxRes + 1);

  typedef logic [7:0]              char_t;
  typedef logic [MaxRes-1:0][7:0]  run_t;
  typedef logic [5:0][7:0]         u16_esc_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNTERM   = 2'd1,
    ERR_OVERLONG = 2'd2,
    ERR_UNSUP    = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    REG_FORCE_ASCII  = 2'd0,
    REG_ESCAPE_SLASH = 2'd1,
    REG_ESCAPE_HTML  = 2'd2
  } reg_idx_t;

  localparam char_t CH_BSLASH = 8'h5c;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_SLASH  = 8'h2f;
  localparam char_t CH_U      = 8'h75;
  localparam char_t CH_B      = 8'h62;
  localparam char_t CH_F      = 8'h66;
  localparam char_t CH_N      = 8'h6e;
  localparam char_t CH_R      = 8'h72;
  localparam char_t CH_T      = 8'h74;
  localparam char_t CH_AMP    = 8'h26;
  localparam char_t CH_LT     = 8'h3c;
  localparam char_t CH_GT     = 8'h3e;
  localparam char_t CH_BS     = 8'h08;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0a;
  localparam char_t CH_FF     = 8'h0c;
  localparam char_t CH_CR     = 8'h0d;

  localparam logic [20:0] MinLen2   = 21'h00080;
  localparam logic [20:0] MinLen3   = 21'h00800;
  localparam logic [20:0] MinLen4   = 21'h10000;
  localparam logic [15:0] SurrHi    = 16'hd800;
  localparam logic [15:0] SurrLo    = 16'hdc00;

  function automatic char_t hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'b0, n}) : (8'h57 + {4'b0, n});
  endfunction

  // \uXXXX, element 0 goes out first
  function automatic u16_esc_t u16_esc(input logic [15:0] v);
    u16_esc_t e;
    e[0] = CH_BSLASH;
    e[1] = CH_U;
    e[2] = hex_char(v[15:12]);
    e[3] = hex_char(v[11:8]);
    e[4] = hex_char(v[7:4]);
    e[5] = hex_char(v[3:0]);
    u16_esc = e;
  endfunction

endpackage

@@ hw/rtl/json_string_escaper_core.sv @@
// json_string_escaper_core: escapes string bytes into JSON string body characters.
// Depends on jse_pkg.
// A transferred byte passes the input register, then the run register, before its
// first character can transfer. Throughput: one byte per cycle while each byte
// yields at most one character and out_stall is low; a multi-character byte holds
// the run register until its last character transfers. Bytes that yield nothing never wait on it.
// Reset (rst_n low, synchronous): pipeline empty, no open sequence, default config.
module json_string_escaper_core
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_end_of_string,
  output logic [1:0] out_error_code
);

  logic force_ascii_r, escape_slash_r, escape_html_r;

  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_last_r;

  logic [23:0] seq_bytes_r, seq_bytes_nxt;
  logic [2:0]  seq_len_r, seq_len_nxt;
  logic [1:0]  seq_cnt_r, seq_cnt_nxt;
  logic        drop_r, drop_nxt;

  logic            b_valid_r;
  run_t            b_chars_r;
  logic [CntW-1:0] b_cnt_r, b_idx_r;
  logic            b_last_r;
  err_t            b_err_r;

  run_t            chars;
  logic [CntW-1:0] res_cnt;
  err_t            err;
  logic [20:0]     ucs, ucs_min, ucs_off;
  logic [15:0]     hi16, lo16;
  logic            b_drain, b_free, a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_ascii_r  <= 1'b1;
      escape_slash_r <= 1'b1;
      escape_html_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORCE_ASCII:  force_ascii_r  <= cfg_wdata;
        REG_ESCAPE_SLASH: escape_slash_r <= cfg_wdata;
        REG_ESCAPE_HTML:  escape_html_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (seq_len_r)
      3'd2: begin
        ucs     = {10'b0, seq_bytes_r[4:0], a_byte_r[5:0]};
        ucs_min = MinLen2;
      end
      3'd3: begin
        ucs     = {5'b0, seq_bytes_r[3:0], seq_bytes_r[13:8], a_byte_r[5:0]};
        ucs_min = MinLen3;
      end
      default: begin
        ucs     = {seq_bytes_r[2:0], seq_bytes_r[13:8], seq_bytes_r[21:16], a_byte_r[5:0]};
        ucs_min = MinLen4;
      end
    endcase
    ucs_off = ucs - MinLen4;
    hi16    = {5'b0, ucs_off[20:10]} + SurrHi;
    lo16    = {6'b0, ucs_off[9:0]} + SurrLo;
  end

  always_comb begin
    seq_bytes_nxt = seq_bytes_r;
    seq_len_nxt   = seq_len_r;
    seq_cnt_nxt   = seq_cnt_r;
    drop_nxt      = drop_r;
    chars         = '0;
    res_cnt       = '0;
    err           = ERR_NONE;
    if (drop_r) begin
      if (a_last_r) drop_nxt = 1'b0;
    end else if (seq_len_r != 3'd0) begin
      if (({1'b0, seq_cnt_r} + 3'd1) < seq_len_r) begin
        seq_bytes_nxt = seq_bytes_r | ({16'b0, a_byte_r} << {seq_cnt_r, 3'b000});
        seq_cnt_nxt   = seq_cnt_r + 2'd1;
        if (a_last_r) err = ERR_UNTERM;
      end else begin
        seq_bytes_nxt = '0;
        seq_len_nxt   = '0;
        seq_cnt_nxt   = '0;
        if (ucs < ucs_min) begin
          err = ERR_OVERLONG;
        end else if (ucs[20:16] != 5'd0) begin
          chars[5:0]  = u16_esc(hi16);
          chars[11:6] = u16_esc(lo16);
          res_cnt     = CntW'(12);
        end else begin
          chars[5:0] = u16_esc(ucs[15:0]);
          res_cnt    = CntW'(6);
        end
      end
    end else if (force_ascii_r && a_byte_r >= 8'hc0 && a_byte_r <= 8'hfd) begin
      if (a_byte_r >= 8'hf8) begin
        err = ERR_UNSUP;
      end else begin
        seq_len_nxt   = (a_byte_r >= 8'hf0) ? 3'd4 : (a_byte_r >= 8'he0) ? 3'd3 : 3'd2;
        seq_bytes_nxt = {16'b0, a_byte_r};
        seq_cnt_nxt   = 2'd1;
        if (a_last_r) err = ERR_UNTERM;
      end
    end else begin
      unique case (a_byte_r)
        CH_QUOTE, CH_BSLASH: begin
          chars[0] = CH_BSLASH;  chars[1] = a_byte_r;  res_cnt = CntW'(2);
        end
        CH_BS:  begin chars[0] = CH_BSLASH;  chars[1] = CH_B;  res_cnt = CntW'(2); end
        CH_FF:  begin chars[0] = CH_BSLASH;  chars[1] = CH_F;  res_cnt = CntW'(2); end
        CH_LF:  begin chars[0] = CH_BSLASH;  chars[1] = CH_N;  res_cnt = CntW'(2); end
        CH_CR:  begin chars[0] = CH_BSLASH;  chars[1] = CH_R;  res_cnt = CntW'(2); end
        CH_TAB: begin chars[0] = CH_BSLASH;  chars[1] = CH_T;  res_cnt = CntW'(2); end
        CH_SLASH: begin
          if (escape_slash_r) begin
            chars[0] = CH_BSLASH;  chars[1] = CH_SLASH;  res_cnt = CntW'(2);
          end else begin
            chars[0] = CH_SLASH;  res_cnt = CntW'(1);
          end
        end
        CH_AMP, CH_LT, CH_GT: begin
          if (escape_html_r) begin
            chars[5:0] = u16_esc({8'b0, a_byte_r});  res_cnt = CntW'(6);
          end else begin
            chars[0] = a_byte_r;  res_cnt = CntW'(1);
          end
        end
        default: begin
          if (a_byte_r < 8'h20) begin
            chars[5:0] = u16_esc({8'b0, a_byte_r});  res_cnt = CntW'(6);
          end else begin
            chars[0] = a_byte_r;  res_cnt = CntW'(1);
          end
        end
      endcase
    end
    if (err != ERR_NONE) begin
      seq_bytes_nxt = '0;
      seq_len_nxt   = '0;
      seq_cnt_nxt   = '0;
      drop_nxt      = !a_last_r;
      chars         = '0;
      res_cnt       = CntW'(1);
    end
  end

  assign b_drain  = b_valid_r && !out_stall && (b_idx_r == b_cnt_r - CntW'(1));
  assign b_free   = !b_valid_r || b_drain;
  assign a_go     = a_valid_r && ((res_cnt == '0) || b_free);
  assign in_stall = a_valid_r && !a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      b_idx_r     <= '0;
      seq_bytes_r <= '0;
      seq_len_r   <= '0;
      seq_cnt_r   <= '0;
      drop_r      <= 1'b0;
    end else begin
      if (!in_stall) a_valid_r <= in_valid;
      if (a_go) begin
        seq_bytes_r <= seq_bytes_nxt;
        seq_len_r   <= seq_len_nxt;
        seq_cnt_r   <= seq_cnt_nxt;
        drop_r      <= drop_nxt;
      end
      if (a_go && res_cnt != '0) begin
        b_valid_r <= 1'b1;
        b_idx_r   <= '0;
      end else if (b_drain) begin
        b_valid_r <= 1'b0;
      end else if (b_valid_r && !out_stall) begin
        b_idx_r <= b_idx_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_byte_r <= in_data_byte;
      a_last_r <= in_last_byte;
    end
    if (a_go && res_cnt != '0) begin
      b_chars_r <= chars;
      b_cnt_r   <= res_cnt;
      b_last_r  <= a_last_r;
      b_err_r   <= err;
    end
  end

  assign out_valid         = b_valid_r;
  assign out_char          = b_chars_r[b_idx_r];
  assign out_last_of_run   = (b_idx_r == b_cnt_r - CntW'(1));
  assign out_end_of_string = out_last_of_run && b_last_r;
  assign out_error_code    = b_err_r;

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_last_of_run && out_char == 8'h00)
    else $error("error result is not a single zero character");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> b_idx_r < b_cnt_r)
    else $error("run index past run length");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r && b_valid_r && res_cnt != '0)
    else $error("input stalled without a pending run");

  a_seq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r != 3'd0 |-> seq_cnt_r != 2'd0 && {1'b0, seq_cnt_r} < seq_len_r && !drop_r)
    else $error("open sequence bookkeeping inconsistent");

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for json_string_escaper_core; random UTF-8 and
// ASCII strings under every config setting, checked against an in-bench escaper.
// Depends on jse_pkg and json_string_escaper_core.
module tb_top
  import jse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_run;
    logic       eos;
    err_t       err;
  } esc_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_last_of_run;
  logic       out_end_of_string;
  logic [1:0] out_error_code;

  json_string_escaper_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_string(out_end_of_string),
    .out_error_code   (out_error_code)
  );

  // escaper state and config as seen by the bench
  logic        force_ascii_on = 1'b1;
  logic        slash_on       = 1'b1;
  logic        html_on        = 1'b0;
  logic [23:0] utf8_acc       = '0;
  logic [2:0]  utf8_len       = '0;
  logic [1:0]  utf8_got       = '0;
  logic        skip_string    = 1'b0;

  in_item_t    byte_q[$];
  logic [7:0]  str_q[$];
  char_t       run_chars[$];
  esc_out_t    exp_chars[$];

  int in_gap_pct    = 30;
  int out_stall_pct = 30;
  int idle_left     = 0;
  int hold_left     = 0;
  int n_mismatch    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic char_t hex_digit(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'b0, n};
    return 8'h61 + {4'b0, n} - 8'd10;
  endfunction

  function automatic void add_u16(input logic [15:0] v);
    run_chars.push_back(CH_BSLASH);
    run_chars.push_back(CH_U);
    run_chars.push_back(hex_digit(v[15:12]));
    run_chars.push_back(hex_digit(v[11:8]));
    run_chars.push_back(hex_digit(v[7:4]));
    run_chars.push_back(hex_digit(v[3:0]));
  endfunction

  function automatic void escape_plain(input logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH: begin
        run_chars.push_back(CH_BSLASH);
        run_chars.push_back(b);
      end
      CH_BS:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(CH_B); end
      CH_FF:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(CH_F); end
      CH_LF:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(CH_N); end
      CH_CR:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(CH_R); end
      CH_TAB: begin run_chars.push_back(CH_BSLASH); run_chars.push_back(CH_T); end
      CH_SLASH: begin
        if (slash_on) run_chars.push_back(CH_BSLASH);
        run_chars.push_back(CH_SLASH);
      end
      CH_AMP, CH_LT, CH_GT: begin
        if (html_on) add_u16({8'h00, b});
        else run_chars.push_back(b);
      end
      default: begin
        if (b < 8'h20) add_u16({8'h00, b});
        else run_chars.push_back(b);
      end
    endcase
  endfunction

  // expected characters for one accepted byte
  function automatic void escape_byte(input logic [7:0] b, input logic last);
    err_t        err;
    logic [20:0] cp;
    logic [20:0] cp_min;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] hi;
    logic [15:0] lo;
    err = ERR_NONE;
    run_chars.delete();
    if (skip_string) begin
      if (last) skip_string = 1'b0;
      return;
    end
    if (utf8_len != 3'd0) begin
      if (int'(utf8_got) + 1 < int'(utf8_len)) begin
        utf8_acc[8*utf8_got +: 8] = b;
        utf8_got = utf8_got + 2'd1;
        if (last) err = ERR_UNTERM;
      end else begin
        b0 = utf8_acc[7:0];
        b1 = utf8_acc[15:8];
        b2 = utf8_acc[23:16];
        if (utf8_len == 3'd2) begin
          cp = {10'b0, b0[4:0], b[5:0]};
          cp_min = MinLen2;
        end else if (utf8_len == 3'd3) begin
          cp = {5'b0, b0[3:0], b1[5:0], b[5:0]};
          cp_min = MinLen3;
        end else begin
          cp = {b0[2:0], b1[5:0], b2[5:0], b[5:0]};
          cp_min = MinLen4;
        end
        utf8_acc = '0;
        utf8_len = '0;
        utf8_got = '0;
        if (cp < cp_min) begin
          err = ERR_OVERLONG;
        end else if (cp >= MinLen4) begin
          cp = cp - MinLen4;
          hi = SurrHi + {5'b0, cp[20:10]};
          lo = SurrLo + {6'b0, cp[9:0]};
          add_u16(hi);
          add_u16(lo);
        end else begin
          add_u16(cp[15:0]);
        end
      end
    end else if (force_ascii_on && b >= 8'hc0 && b <= 8'hfd) begin
      if (b >= 8'hf8) begin
        err = ERR_UNSUP;
      end else begin
        utf8_len = (b >= 8'hf0) ? 3'd4 : (b >= 8'he0) ? 3'd3 : 3'd2;
        utf8_acc = {16'b0, b};
        utf8_got = 2'd1;
        if (last) err = ERR_UNTERM;
      end
    end else begin
      escape_plain(b);
    end

    if (err != ERR_NONE) begin
      utf8_acc = '0;
      utf8_len = '0;
      utf8_got = '0;
      skip_string = !last;
      exp_chars.push_back('{8'h00, 1'b1, last, err});
      return;
    end
    foreach (run_chars[k])
      exp_chars.push_back('{run_chars[k], k == run_chars.size() - 1,
                            (k == run_chars.size() - 1) && last, ERR_NONE});
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) != 0) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // continuation byte, top bits sometimes wrong since the block never checks them
  function automatic logic [7:0] cont_byte(input logic [5:0] v);
    if ($urandom_range(6) == 0) return {2'($urandom_range(3)), v};
    return {2'b10, v};
  endfunction

  function automatic void add_utf8(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      2: begin
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back(cont_byte(cp[5:0]));
      end
      3: begin
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back(cont_byte(cp[11:6]));
        str_q.push_back(cont_byte(cp[5:0]));
      end
      default: begin
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back(cont_byte(cp[17:12]));
        str_q.push_back(cont_byte(cp[11:6]));
        str_q.push_back(cont_byte(cp[5:0]));
      end
    endcase
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(12))
      0:  return CH_QUOTE;
      1:  return CH_BSLASH;
      2:  return CH_BS;
      3:  return CH_FF;
      4:  return CH_LF;
      5:  return CH_CR;
      6:  return CH_TAB;
      7:  return CH_SLASH;
      8:  return CH_AMP;
      9:  return CH_LT;
      10: return CH_GT;
      11: return 8'h7f;
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic void add_token();
    int          pick;
    int          nb;
    int          cut;
    logic [20:0] cp;
    pick = $urandom_range(99);
    nb = $urandom_range(2, 4);
    if (pick < 25) begin
      str_q.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 40) begin
      str_q.push_back(special_char());
    end else if (pick < 45) begin
      str_q.push_back(8'($urandom_range(128, 255)));
    end else if (pick < 80) begin
      case (nb)
        2: cp = ($urandom_range(7) == 0) ? 21'h7ff : 21'($urandom_range(21'h80, 21'h7ff));
        3: cp = ($urandom_range(4) == 0) ? 21'($urandom_range(21'hd800, 21'hdfff))
                                         : 21'($urandom_range(21'h800, 21'hffff));
        default: cp = ($urandom_range(7) == 0) ? 21'h1fffff
                                               : 21'($urandom_range(21'h10000, 21'h1fffff));
      endcase
      add_utf8(cp, nb);
    end else if (pick < 88) begin
      case (nb)
        2: cp = 21'($urandom_range(0, 21'h7f));
        3: cp = 21'($urandom_range(0, 21'h7ff));
        default: cp = 21'($urandom_range(0, 21'hffff));
      endcase
      add_utf8(cp, nb);
    end else if (pick < 93) begin
      str_q.push_back(8'($urandom_range(8'hf8, 8'hfd)));
    end else begin
      add_utf8(21'($urandom_range(21'h80, 21'h1fffff)), nb);
      cut = $urandom_range(1, nb - 1);
      repeat (cut) void'(str_q.pop_back());
    end
  endfunction

  function automatic int queue_string();
    int n;
    foreach (str_q[i]) byte_q.push_back('{str_q[i], i == str_q.size() - 1});
    n = str_q.size();
    str_q.delete();
    return n;
  endfunction

  function automatic int queue_random_string();
    int n_tok;
    n_tok = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 8);
    repeat (n_tok) add_token();
    return queue_string();
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FORCE_ASCII:  force_ascii_on = val;
      REG_ESCAPE_SLASH: slash_on = val;
      REG_ESCAPE_HTML:  html_on = val;
      default: ;
    endcase
  endtask

  // all bytes sent, all characters back, then a settling wait for bytes with no output
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_valid || exp_chars.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive
    in_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) escape_byte(in_data_byte, in_last_byte);
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          nxt = byte_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
          idle_left = pick_gap(in_gap_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    esc_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_chars.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected transfer: char %h lor %b eos %b err %0d",
                     out_char, out_last_of_run, out_end_of_string, out_error_code);
        end else begin
          want = exp_chars.pop_front();
          if (out_char !== want.ch || out_last_of_run !== want.last_run ||
              out_end_of_string !== want.eos || out_error_code !== want.err) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: exp %h/%b/%b/%0d, got %h/%b/%b/%0d",
                       want.ch, want.last_run, want.eos, want.err,
                       out_char, out_last_of_run, out_end_of_string, out_error_code);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        hold_left = pick_gap(out_stall_pct);
      end
    end
  end

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_FORCE_ASCII, 1'b1);
    write_reg(REG_ESCAPE_SLASH, 1'b1);
    write_reg(REG_ESCAPE_HTML, 1'b1);
    write_reg(RegSpare, 1'b1);
    @(negedge clk);

    // every escape class, raw high bytes, 2/3/4-byte sequences incl. surrogate range
    str_q = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB, CH_SLASH,
              CH_AMP, 8'h00, 8'h80, 8'hff, 8'hc3, 8'ha9, 8'hed, 8'ha0, 8'h80,
              8'hf0, 8'h9f, 8'h98, 8'h80};
    void'(queue_string());
    // overlong, then the rest of the string is dropped
    str_q = '{8'hc1, 8'hbf, 8'h41};
    void'(queue_string());
    // unsupported lead, then a lead cut short by the end of the string
    str_q = '{8'hf8};
    void'(queue_string());
    str_q = '{8'he2};
    void'(queue_string());

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_reg(REG_FORCE_ASCII, ~p[0]);
      write_reg(REG_ESCAPE_SLASH, p[1]);
      write_reg(REG_ESCAPE_HTML, p[2]);
      if (p == 5) write_reg(RegSpare, 1'b0);
      in_gap_pct    = (p == 1 || p == 4) ? 0 : 35;
      out_stall_pct = (p == 2 || p == 4) ? 0 : 35;
      @(negedge clk);
      sent = 0;
      while (sent < 38) sent += queue_random_string();
    end

    wait_drained();
    if (n_mismatch == 0 && exp_chars.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
